>>> rtl/gmcm_pkg.sv
`default_nettype none

package gmcm_pkg;

    localparam int MAX_GROUP  = 8;
    localparam int INDEX_REACH = 8;
    localparam int GROUP_CAP  = (MAX_GROUP < INDEX_REACH) ? MAX_GROUP : INDEX_REACH;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [3:0]  GROUP_SIZE_RST = 4'd1;
    localparam logic [15:0] TOLERANCE_RST  = 16'd50;
    localparam logic [15:0] SPREAD_RST     = 16'd150;
    localparam logic [15:0] POS_MAX        = 16'hFFFF;
    localparam logic [31:0] ELAPSED_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUP_SIZE = 2'd0,
        CFG_TOLERANCE  = 2'd1,
        CFG_SPREAD     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_TICK   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_MOVING  = 3'd1,
        ST_OK      = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_DESYNC  = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] goal_position;
        logic [31:0] timeout_limit;
        logic [2:0]  actuator_index;
        logic [15:0] present_position;
        logic        is_moving;
    } t_req;

    typedef struct packed {
        logic [2:0]  move_status;
        logic [15:0] position_spread;
        logic        all_in_tolerance;
        logic        all_halted;
    } t_rsp;

endpackage

`default_nettype wire

>>> rtl/gmcm_req_if.sv
`default_nettype none

interface gmcm_req_if import gmcm_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/gmcm_rsp_if.sv
`default_nettype none

interface gmcm_rsp_if import gmcm_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/group_move_completion_monitor_unit.sv
`default_nettype none

// Channel   Direction  Handshake     Payload
// i_req     in         valid/ready   action, target, timeout, index, position, moving
// o_rsp     out        valid/ready   status, spread, all in tolerance, all halted
// i_cfg_*   in         write enable  group size, tolerance, spread limit
//
// Each request yields one response; it passes the input register, then the result registers.
// While responses are taken, one request per cycle is sustained: a one-deep input register feeds
// the state update, and the held result registers double as the output register.
// Reset is synchronous; it loads the default configuration and clears the state and both valids.
// A stalled response holds the update stage; an empty input register still takes one request.

module group_move_completion_monitor_unit import gmcm_pkg::*; #(
    parameter int GROUP_MAX = MAX_GROUP
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    gmcm_req_if.sink              i_req,
    gmcm_rsp_if.source            o_rsp
);

    localparam int SIZE_CAP = (GROUP_MAX < INDEX_REACH) ? GROUP_MAX : INDEX_REACH;

    logic [3:0]  r_group_size;
    logic [15:0] r_tolerance;
    logic [15:0] r_spread_limit;

    logic        r_in_valid;
    t_req        r_req;
    logic        r_out_valid;

    logic        r_armed,    n_armed;
    logic [15:0] r_goal,     n_goal;
    logic [31:0] r_allowed,  n_allowed;
    logic [31:0] r_elapsed,  n_elapsed;
    logic        r_within,   n_within;
    logic        r_stopped,  n_stopped;
    logic        r_close,    n_close;
    logic [15:0] r_min,      n_min;
    logic [15:0] r_max,      n_max;
    t_status     r_status,   n_status;
    logic [15:0] r_h_spread, n_h_spread;
    logic        r_h_within, n_h_within;
    logic        r_h_halted, n_h_halted;

    logic        s_fire;
    logic [3:0]  s_eff_size;
    logic [3:0]  s_index;
    logic        s_in_round;
    logic        s_first;
    logic        s_last;
    logic        s_b_within;
    logic        s_b_stopped;
    logic        s_b_close;
    logic [15:0] s_b_min;
    logic [15:0] s_b_max;
    logic [15:0] s_dist;
    logic        f_within;
    logic        f_stopped;
    logic        f_close;
    logic [15:0] f_min;
    logic [15:0] f_max;
    logic [15:0] s_spread;
    logic        s_timeout;
    t_status     s_decision;
    logic        s_terminal;

    assign s_fire      = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || s_fire;

    assign o_rsp.valid                 = r_out_valid;
    assign o_rsp.data.move_status      = r_status;
    assign o_rsp.data.position_spread  = r_h_spread;
    assign o_rsp.data.all_in_tolerance = r_h_within;
    assign o_rsp.data.all_halted       = r_h_halted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size   <= GROUP_SIZE_RST;
            r_tolerance    <= TOLERANCE_RST;
            r_spread_limit <= SPREAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GROUP_SIZE: r_group_size   <= i_cfg_wdata[3:0];
                CFG_TOLERANCE:  r_tolerance    <= i_cfg_wdata;
                CFG_SPREAD:     r_spread_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        if (r_group_size == 4'd0) begin
            s_eff_size = 4'd1;
        end else if (r_group_size > 4'(SIZE_CAP)) begin
            s_eff_size = 4'(SIZE_CAP);
        end else begin
            s_eff_size = r_group_size;
        end
    end

    assign s_index    = {1'b0, r_req.actuator_index};
    assign s_in_round = s_index < s_eff_size;
    assign s_first    = r_req.actuator_index == 3'd0;
    assign s_last     = s_index == (s_eff_size - 4'd1);

    assign s_b_within  = s_first ? 1'b1    : r_within;
    assign s_b_stopped = s_first ? 1'b1    : r_stopped;
    assign s_b_close   = s_first ? 1'b1    : r_close;
    assign s_b_min     = s_first ? POS_MAX : r_min;
    assign s_b_max     = s_first ? 16'd0   : r_max;

    assign s_dist = (r_req.present_position >= r_goal) ?
                    (r_req.present_position - r_goal) :
                    (r_goal - r_req.present_position);

    assign f_within  = s_b_within && (s_dist <= r_tolerance);
    assign f_close   = s_b_close && ({1'b0, s_dist} <= {r_tolerance, 1'b0});
    assign f_stopped = s_b_stopped && !r_req.is_moving;
    assign f_min     = (r_req.present_position < s_b_min) ? r_req.present_position : s_b_min;
    assign f_max     = (r_req.present_position > s_b_max) ? r_req.present_position : s_b_max;

    assign s_spread  = (s_eff_size >= 4'd2 && f_max >= f_min) ? (f_max - f_min) : 16'd0;
    assign s_timeout = r_elapsed > r_allowed;

    always_comb begin
        s_terminal = 1'b1;
        if (s_timeout) begin
            s_decision = ST_TIMEOUT;
        end else if (f_within) begin
            s_decision = ST_OK;
        end else if (f_stopped && (s_spread > r_spread_limit)) begin
            s_decision = ST_DESYNC;
        end else if (f_stopped && f_close) begin
            s_decision = ST_OK;
        end else begin
            s_decision = ST_MOVING;
            s_terminal = 1'b0;
        end
    end

    always_comb begin
        n_armed    = r_armed;
        n_goal     = r_goal;
        n_allowed  = r_allowed;
        n_elapsed  = r_elapsed;
        n_within   = r_within;
        n_stopped  = r_stopped;
        n_close    = r_close;
        n_min      = r_min;
        n_max      = r_max;
        n_status   = r_status;
        n_h_spread = r_h_spread;
        n_h_within = r_h_within;
        n_h_halted = r_h_halted;
        if (s_fire) begin
            case (r_req.action)
                ACT_START: begin
                    n_armed    = 1'b1;
                    n_goal     = r_req.goal_position;
                    n_allowed  = r_req.timeout_limit;
                    n_elapsed  = 32'd0;
                    n_within   = 1'b1;
                    n_stopped  = 1'b1;
                    n_close    = 1'b1;
                    n_min      = POS_MAX;
                    n_max      = 16'd0;
                    n_status   = ST_MOVING;
                    n_h_spread = 16'd0;
                    n_h_within = 1'b0;
                    n_h_halted = 1'b0;
                end
                ACT_SAMPLE: begin
                    if (r_armed && s_in_round) begin
                        if (s_last) begin
                            n_h_spread = s_spread;
                            n_h_within = f_within;
                            n_h_halted = f_stopped;
                            n_status   = s_decision;
                            n_armed    = !s_terminal;
                            n_within   = 1'b1;
                            n_stopped  = 1'b1;
                            n_close    = 1'b1;
                            n_min      = POS_MAX;
                            n_max      = 16'd0;
                        end else begin
                            n_within  = f_within;
                            n_stopped = f_stopped;
                            n_close   = f_close;
                            n_min     = f_min;
                            n_max     = f_max;
                        end
                    end
                end
                ACT_TICK: begin
                    if (r_armed && r_elapsed != ELAPSED_MAX) begin
                        n_elapsed = r_elapsed + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_goal     <= 16'd0;
            r_allowed  <= 32'd0;
            r_elapsed  <= 32'd0;
            r_within   <= 1'b1;
            r_stopped  <= 1'b1;
            r_close    <= 1'b1;
            r_min      <= POS_MAX;
            r_max      <= 16'd0;
            r_status   <= ST_IDLE;
            r_h_spread <= 16'd0;
            r_h_within <= 1'b0;
            r_h_halted <= 1'b0;
        end else begin
            r_armed    <= n_armed;
            r_goal     <= n_goal;
            r_allowed  <= n_allowed;
            r_elapsed  <= n_elapsed;
            r_within   <= n_within;
            r_stopped  <= n_stopped;
            r_close    <= n_close;
            r_min      <= n_min;
            r_max      <= n_max;
            r_status   <= n_status;
            r_h_spread <= n_h_spread;
            r_h_within <= n_h_within;
            r_h_halted <= n_h_halted;
        end
    end

endmodule

`default_nettype wire
